FILE: hdl/irpwcd_pkg.sv
// ----------------------------------------------------------------------------
// irpwcd_pkg
// shared types and constants of the infrared pulse width code decoder
// ----------------------------------------------------------------------------
package irpwcd_pkg;

  localparam int unsigned TIME_W        = 16;
  localparam int unsigned KEY_W         = 7;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam int unsigned FRAME_EDGES_DEF = 18;
  localparam int unsigned CODE_BITS_DEF   = 7;

  typedef logic [TIME_W-1:0]     time_t;
  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_START_MIN = 2'd0;
  localparam cfg_idx_t REG_GAP_MIN   = 2'd1;
  localparam cfg_idx_t REG_GAP_MAX   = 2'd2;
  localparam cfg_idx_t REG_ONE_THR   = 2'd3;

  localparam time_t START_MIN_RST = 16'd2000;
  localparam time_t GAP_MIN_RST   = 16'd300;
  localparam time_t GAP_MAX_RST   = 16'd600;
  localparam time_t ONE_THR_RST   = 16'd1000;

endpackage

FILE: hdl/irpwcd_ifs.sv
// ----------------------------------------------------------------------------
// irpwcd stream interfaces
// valid/ready channels for edge timestamps and decoded key codes
// ----------------------------------------------------------------------------
interface irpwcd_in_if;
  logic                 valid;
  logic                 ready;
  irpwcd_pkg::time_t    capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface

interface irpwcd_out_if;
  logic                 valid;
  logic                 ready;
  irpwcd_pkg::key_t     key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

FILE: hdl/ir_pulse_width_code_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_code_decoder
// decodes pulse width coded infrared frames from edge timestamps
// ----------------------------------------------------------------------------
// One capture timestamp per receiver edge is taken per clock cycle while the
// output is not stalled. Each transfer lands in an input register; from there
// the width to the previous edge is measured, checked against the start or
// gap limits or turned into a code bit; at frame end the output register is
// written. A full frame of FRAME_EDGES timestamps gives at most one key code,
// dropped if any check failed. An output stall holds the input register and,
// once it is full, the input. The user must write the limits through the cfg
// port only while idle; the block itself does not enforce this.
module ir_pulse_width_code_decoder #(
  parameter int unsigned FRAME_EDGES = irpwcd_pkg::FRAME_EDGES_DEF,
  parameter int unsigned CODE_BITS   = irpwcd_pkg::CODE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  irpwcd_in_if.sink             in_ch,
  irpwcd_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  irpwcd_pkg::cfg_idx_t  cfg_idx,
  input  irpwcd_pkg::cfg_data_t cfg_wdata
);

  import irpwcd_pkg::*;

  localparam int unsigned EW   = $clog2(FRAME_EDGES);
  localparam int unsigned KEEP = (CODE_BITS < KEY_W) ? CODE_BITS : KEY_W;

  // limit registers
  time_t start_min_r, gap_min_r, gap_max_r, one_thr_r;

  // input stage
  logic  s1_valid_r;
  time_t s1_time_r;

  // frame state
  time_t          prev_r, prev_nxt;
  logic [EW-1:0]  edge_r, edge_nxt;
  logic           good_r, good_nxt;
  logic [KEEP-1:0] code_r, code_nxt;

  // output stage
  logic  out_valid_r, out_valid_nxt;
  key_t  key_r, key_nxt;

  logic          advance;
  logic          in_xfer;
  time_t         width;
  logic [EW-1:0] w_idx;
  logic [EW-1:0] bit_idx;
  logic [EW:0]   edge_inc;
  logic          emit;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.key_code = key_r;

  always_comb begin
    width    = s1_time_r - prev_r;
    w_idx    = edge_r - EW'(1);
    bit_idx  = (w_idx >> 1) - EW'(1);
    edge_inc = {1'b0, edge_r} + (EW+1)'(1);
    prev_nxt = s1_time_r;
    good_nxt = good_r;
    code_nxt = code_r;
    edge_nxt = edge_inc[EW-1:0];
    emit     = 1'b0;
    if (edge_r == '0) begin
      good_nxt = 1'b1;
      code_nxt = '0;
      edge_nxt = EW'(1);
    end else begin
      if (w_idx == '0) begin
        if (width < start_min_r) begin
          good_nxt = 1'b0;
        end
      end else if (w_idx[0]) begin
        if ((width < gap_min_r) || (width > gap_max_r)) begin
          good_nxt = 1'b0;
        end
      end else begin
        for (int i = 0; i < KEEP; i++) begin
          if ((int'(bit_idx) == i) && (width >= one_thr_r)) begin
            code_nxt[i] = 1'b1;
          end
        end
      end
      if (edge_inc == (EW+1)'(FRAME_EDGES)) begin
        edge_nxt = '0;
        emit     = good_nxt;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    key_nxt       = key_r;
    if (s1_valid_r && advance && emit) begin
      out_valid_nxt = 1'b1;
      key_nxt       = KEY_W'(code_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_min_r <= START_MIN_RST;
      gap_min_r   <= GAP_MIN_RST;
      gap_max_r   <= GAP_MAX_RST;
      one_thr_r   <= ONE_THR_RST;
      s1_valid_r  <= 1'b0;
      prev_r      <= '0;
      edge_r      <= '0;
      good_r      <= 1'b1;
      code_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_START_MIN: start_min_r <= cfg_wdata;
          REG_GAP_MIN:   gap_min_r   <= cfg_wdata;
          REG_GAP_MAX:   gap_max_r   <= cfg_wdata;
          REG_ONE_THR:   one_thr_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_valid_r && advance) begin
        prev_r <= prev_nxt;
        edge_r <= edge_nxt;
        good_r <= good_nxt;
        code_r <= code_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_time_r <= in_ch.capture_time;
    end
    key_r <= key_nxt;
  end

endmodule

FILE: hdl/irpwcd_checker.sv
// ----------------------------------------------------------------------------
// irpwcd_checker
// port level checks of the infrared pulse width code decoder
// ----------------------------------------------------------------------------
module irpwcd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input irpwcd_pkg::key_t    key_code
);

  import irpwcd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(key_code)))
    else $error("key code changed while stalled");

  // no result straight after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // empty output never blocks the input
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a new result follows an earlier input transfer
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without preceding transfer");

endmodule

bind ir_pulse_width_code_decoder irpwcd_checker u_irpwcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .key_code  (out_ch.key_code)
);
